// ----- src/bq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad filter package
// Shared constants, register indexes and the coefficient set type.
// ----------------------------------------------------------------------------
package bq_pkg;

	localparam int SAMPLE_WIDTH_DEF   = 24;
	localparam int COEF_FRAC_BITS_DEF = 20;
	localparam int COEF_WIDTH         = 24;
	localparam int NUM_COEFS          = 5;
	localparam int CFG_INDEX_W        = 3;
	localparam int CFG_DATA_W         = COEF_WIDTH;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_B0 = 3'd0,
		CFG_B1 = 3'd1,
		CFG_B2 = 3'd2,
		CFG_A1 = 3'd3,
		CFG_A2 = 3'd4
	} cfg_idx_t;

	typedef logic signed [COEF_WIDTH-1:0] coef_t;

	typedef struct packed {
		coef_t b0;
		coef_t b1;
		coef_t b2;
		coef_t a1;
		coef_t a2;
	} coef_set_t;

endpackage
`default_nettype wire

// ----- src/bq_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad filter channels
// Valid/ready channels for input samples, filtered results and register writes.
// ----------------------------------------------------------------------------
interface bq_sample_if #(
	parameter int SAMPLE_WIDTH = bq_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface bq_result_if #(
	parameter int SAMPLE_WIDTH = bq_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] filtered_sample;
	logic                           clipped;

	modport source (output valid, output filtered_sample, output clipped, input ready);
	modport sink (input valid, input filtered_sample, input clipped, output ready);
endinterface

interface bq_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bq_pkg::CFG_INDEX_W-1:0]  index;
	logic [bq_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/bq_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad arithmetic
// Five products, full-width sum, round half up and saturation to the sample width.
// ----------------------------------------------------------------------------
module bq_datapath #(
	parameter int SAMPLE_WIDTH   = bq_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = bq_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire bq_pkg::coef_set_t          coefs,
	input  wire logic signed [SAMPLE_WIDTH-1:0] x,
	input  wire logic signed [SAMPLE_WIDTH-1:0] x1,
	input  wire logic signed [SAMPLE_WIDTH-1:0] x2,
	input  wire logic signed [SAMPLE_WIDTH-1:0] y1,
	input  wire logic signed [SAMPLE_WIDTH-1:0] y2,
	output logic signed [SAMPLE_WIDTH-1:0]      y,
	output logic                                clip
);

	localparam int PROD_W = bq_pkg::COEF_WIDTH + SAMPLE_WIDTH;
	localparam int ACC_W  = PROD_W + 3;
	localparam logic signed [ACC_W-1:0] RND =
		{{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
	localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	logic signed [PROD_W-1:0]          p0, p1, p2, p3, p4;
	logic signed [ACC_W-1:0]           acc;
	logic signed [ACC_W-1:0]           rnd;
	logic [ACC_W-SAMPLE_WIDTH:0]       hi;
	logic                              ovf;

	assign p0 = PROD_W'(coefs.b0) * PROD_W'(x);
	assign p1 = PROD_W'(coefs.b1) * PROD_W'(x1);
	assign p2 = PROD_W'(coefs.b2) * PROD_W'(x2);
	assign p3 = PROD_W'(coefs.a1) * PROD_W'(y1);
	assign p4 = PROD_W'(coefs.a2) * PROD_W'(y2);

	assign acc = {{3{p0[PROD_W-1]}}, p0} + {{3{p1[PROD_W-1]}}, p1}
		+ {{3{p2[PROD_W-1]}}, p2} - {{3{p3[PROD_W-1]}}, p3}
		- {{3{p4[PROD_W-1]}}, p4} + RND;
	assign rnd = acc >>> COEF_FRAC_BITS;

	// The rounded value fits when all bits from the sample sign upward agree.
	assign hi  = rnd[ACC_W-1:SAMPLE_WIDTH-1];
	assign ovf = !((&hi) || (~|hi));

	always_comb begin
		if (ovf) begin
			y = rnd[ACC_W-1] ? SAT_MIN : SAT_MAX;
		end else begin
			y = rnd[SAMPLE_WIDTH-1:0];
		end
		clip = ovf;
	end

endmodule
`default_nettype wire

// ----- src/biquad_iir_filter_core.sv -----
`default_nettype none
// A sample word is registered in x_s1, then its result in y_s2; a result that is
// not taken holds back new samples. One sample word per cycle while results are
// taken; the feedback path through the five multipliers, the sum and the saturation is combinational.
// Reset clears the sample and output history, restores b0 to unity and the
// other coefficients to zero, and empties both pipeline registers.
// ----------------------------------------------------------------------------
// Biquad IIR filter core
// Direct form I second-order section with register-programmed coefficients.
// ----------------------------------------------------------------------------
module biquad_iir_filter_core #(
	parameter int SAMPLE_WIDTH   = bq_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = bq_pkg::COEF_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	bq_sample_if.sink   samples,
	bq_result_if.source results,
	bq_cfg_if.sink      cfg
);

	localparam bq_pkg::coef_t UNITY = bq_pkg::COEF_WIDTH'(64'd1 << COEF_FRAC_BITS);
	localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	bq_pkg::coef_set_t               coef_q;
	logic                            valid_s1;
	logic signed [SAMPLE_WIDTH-1:0]  x_s1;
	logic                            valid_s2;
	logic signed [SAMPLE_WIDTH-1:0]  y_s2;
	logic                            clip_s2;
	logic signed [SAMPLE_WIDTH-1:0]  x1_q, x2_q, y1_q, y2_q;
	logic signed [SAMPLE_WIDTH-1:0]  y_new;
	logic                            clip_new;
	logic                            advance;

	assign advance       = valid_s1 && (!valid_s2 || results.ready);
	assign samples.ready = !valid_s1 || advance;
	assign cfg.ready     = 1'b1;

	assign results.valid           = valid_s2;
	assign results.filtered_sample = y_s2;
	assign results.clipped         = clip_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= UNITY;
			coef_q.b1 <= '0;
			coef_q.b2 <= '0;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				bq_pkg::CFG_B0: coef_q.b0 <= cfg.data;
				bq_pkg::CFG_B1: coef_q.b1 <= cfg.data;
				bq_pkg::CFG_B2: coef_q.b2 <= cfg.data;
				bq_pkg::CFG_A1: coef_q.a1 <= cfg.data;
				bq_pkg::CFG_A2: coef_q.a2 <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			x_s1 <= samples.sample_in;
		end
	end

	bq_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_datapath (
		.coefs (coef_q),
		.x     (x_s1),
		.x1    (x1_q),
		.x2    (x2_q),
		.y1    (y1_q),
		.y2    (y2_q),
		.y     (y_new),
		.clip  (clip_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (advance) begin
			x1_q <= x_s1;
			x2_q <= x1_q;
			y1_q <= y_new;
			y2_q <= y1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			y_s2    <= y_new;
			clip_s2 <= clip_new;
		end
	end

`ifndef SYNTHESIS
	a_clip_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && clip_s2 |-> (y_s2 == SAT_MAX || y_s2 == SAT_MIN))
		else $error("clipped word is not at a saturation bound");

	a_history_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(y1_q) && $stable(x1_q))
		else $error("history changed without a word advancing");

	a_history_tracks_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> y1_q == y_s2 && valid_s2)
		else $error("stored output history differs from the emitted word");

	a_coef_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready && cfg.index == bq_pkg::CFG_A1 |=> coef_q.a1 == $past(cfg.data))
		else $error("coefficient a1 write lost");
`endif

endmodule
`default_nettype wire
